// File: src/sprrle_pkg.sv
// ----------------------------------------------------------------------------
// Sprite RLE row decoder package
// Types and constants shared by the row decoder and its span clipper.
// ----------------------------------------------------------------------------
package sprrle_pkg;

    // Parser phase of the row command stream.
    typedef enum logic [2:0] {
        PH_ROW_START  = 3'd0,
        PH_CMD        = 3'd1,
        PH_LONG_LO    = 3'd2,
        PH_FILL_LEN   = 3'd3,
        PH_FILL_COLOR = 3'd4,
        PH_PIXELS     = 3'd5,
        PH_EXT        = 3'd6
    } t_phase;

    // Command codes carried in the low nibble of a command byte.
    localparam logic [3:0] KIND_SHORT_DRAW_0 = 4'h0;
    localparam logic [3:0] KIND_SHORT_SKIP_0 = 4'h1;
    localparam logic [3:0] KIND_LONG_DRAW    = 4'h2;
    localparam logic [3:0] KIND_LONG_SKIP    = 4'h3;
    localparam logic [3:0] KIND_SHORT_DRAW_1 = 4'h4;
    localparam logic [3:0] KIND_SHORT_SKIP_1 = 4'h5;
    localparam logic [3:0] KIND_PLAYER_DRAW  = 4'h6;
    localparam logic [3:0] KIND_FILL         = 4'h7;
    localparam logic [3:0] KIND_SHORT_DRAW_2 = 4'h8;
    localparam logic [3:0] KIND_SHORT_SKIP_2 = 4'h9;
    localparam logic [3:0] KIND_PLAYER_FILL  = 4'hA;
    localparam logic [3:0] KIND_SHADOW_FILL  = 4'hB;
    localparam logic [3:0] KIND_SHORT_DRAW_3 = 4'hC;
    localparam logic [3:0] KIND_SHORT_SKIP_3 = 4'hD;
    localparam logic [3:0] KIND_EXTENDED     = 4'hE;
    localparam logic [3:0] KIND_END_ROW      = 4'hF;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Field widths and fixed values.
    localparam int CFG_W     = 13;
    localparam int COORD_W   = 12;
    localparam int COLUMN_W  = 16;
    localparam int OFFSET_W  = 16;
    localparam int COLOR_W   = 8;

    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = 13'd480;
    localparam logic [COLOR_W-1:0] PLAYER_COLOR_OFS = 8'd16;
    localparam logic [COLOR_W-1:0] SHADOW_COLOR     = 8'd0;

    // Span placement request toward the clipper.
    typedef struct packed {
        logic [COLUMN_W-1:0]        column;
        logic signed [OFFSET_W-1:0] offset;
        logic [COORD_W-1:0]         length;
        logic [COORD_W-1:0]         row;
        logic [CFG_W-1:0]           frame_width;
        logic [CFG_W-1:0]           frame_height;
    } t_clip_req;

    // Clipped span back from the clipper.
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] run_length;
        logic [CFG_W-1:0]   width_eff;
    } t_clip_res;

endpackage

// File: src/sprite_rle_row_decoder_top.sv
// ----------------------------------------------------------------------------
// Sprite RLE row decoder
// Decodes a sprite row command stream one byte per word into clipped spans
// and row-end markers.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_stall   i_data_byte, i_row, i_left_offset
//  output    out        o_valid / i_stall   o_out_row, o_x_start, o_run_length,
//                                           o_pixel_color, o_row_end
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
//  One word is accepted per cycle unless the output stalls; each word yields
//  zero or one output word. A word passes an input register, then decode and
//  clip logic that loads the output register.
//  The input register holds while the output register is full and stalled.
//  Synchronous active-low reset returns the parser to the start of a row and
//  restores frame width 640 and height 480.
//
module sprite_rle_row_decoder_top #(
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Byte stream input
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic [7:0]                                i_data_byte,
    input  logic [sprrle_pkg::COORD_W-1:0]            i_row,
    input  logic signed [sprrle_pkg::OFFSET_W-1:0]    i_left_offset,
    // Span output
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [sprrle_pkg::COORD_W-1:0]            o_out_row,
    output logic [sprrle_pkg::COORD_W-1:0]            o_x_start,
    output logic [sprrle_pkg::COORD_W-1:0]            o_run_length,
    output logic [sprrle_pkg::COLOR_W-1:0]            o_pixel_color,
    output logic                                      o_row_end,
    // Configuration writes
    input  logic                                      i_cfg_we,
    input  logic                                      i_cfg_index,
    input  logic [sprrle_pkg::CFG_W-1:0]              i_cfg_data
);
    import sprrle_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    // Input register
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic [COORD_W-1:0]         r_in_row;
    logic signed [OFFSET_W-1:0] r_in_offset;

    // Parser state
    t_phase                     r_phase,   n_phase;
    logic [3:0]                 r_kind,    n_kind;
    logic [COORD_W-1:0]         r_remaining, n_remaining;
    logic [COLUMN_W-1:0]        r_column,  n_column;
    logic [COORD_W-1:0]         r_row,     n_row;
    logic signed [OFFSET_W-1:0] r_offset,  n_offset;

    // Output register
    logic                       r_out_valid;
    logic [COORD_W-1:0]         r_out_row;
    logic [COORD_W-1:0]         r_out_x;
    logic [COORD_W-1:0]         r_out_run;
    logic [COLOR_W-1:0]         r_out_color;
    logic                       r_out_end;

    // Decode signals
    logic                       stage_adv;
    logic                       out_free;
    logic [COLUMN_W-1:0]        cur_column;
    logic [COORD_W-1:0]         cur_row;
    logic signed [OFFSET_W-1:0] cur_offset;
    logic [COORD_W-1:0]         cur_remaining;
    logic                       do_adv;
    logic [COORD_W-1:0]         adv_len;
    logic                       do_span;
    logic [COLOR_W-1:0]         span_color;
    logic                       marker;
    logic                       do_start;
    logic [COORD_W-1:0]         start_count;
    logic [3:0]                 start_kind;
    logic [COORD_W-1:0]         long_sum;
    logic [COLUMN_W:0]          col_sum;
    logic [COLOR_W-1:0]         byte_plus;
    logic                       res_valid;
    t_clip_req                  clip_req;
    t_clip_res                  clip_res;

    // Handshake between the two register stages.
    assign out_free  = !r_out_valid || !i_stall;
    assign stage_adv = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end else begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte   <= i_data_byte;
            r_in_row    <= i_row;
            r_in_offset <= i_left_offset;
        end
    end

    // The first byte of a row latches row and offset and restarts the column.
    always_comb begin
        if (r_phase == PH_ROW_START) begin
            cur_column    = '0;
            cur_row       = r_in_row;
            cur_offset    = r_in_offset;
            cur_remaining = '0;
        end else begin
            cur_column    = r_column;
            cur_row       = r_row;
            cur_offset    = r_offset;
            cur_remaining = r_remaining;
        end
    end

    assign byte_plus = r_in_byte + PLAYER_COLOR_OFS;
    assign long_sum  = cur_remaining + {4'd0, r_in_byte};

    // Next parser state and the word this byte produces.
    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_remaining = cur_remaining;
        n_row       = cur_row;
        n_offset    = cur_offset;
        do_adv      = 1'b0;
        adv_len     = '0;
        do_span     = 1'b0;
        span_color  = r_in_byte;
        marker      = 1'b0;
        do_start    = 1'b0;
        start_count = '0;
        start_kind  = r_kind;

        unique case (r_phase)
            PH_LONG_LO: begin
                n_phase     = PH_CMD;
                n_remaining = long_sum;
                if (r_kind == KIND_LONG_SKIP) begin
                    do_adv      = 1'b1;
                    adv_len     = long_sum;
                    n_remaining = '0;
                end else if (long_sum != '0) begin
                    n_phase = PH_PIXELS;
                end
            end
            PH_FILL_LEN: begin
                do_start    = 1'b1;
                start_count = {4'd0, r_in_byte};
            end
            PH_FILL_COLOR: begin
                n_phase    = PH_CMD;
                span_color = (r_kind == KIND_PLAYER_FILL) ? byte_plus : r_in_byte;
                do_span    = 1'b1;
                do_adv     = 1'b1;
                adv_len    = cur_remaining;
            end
            PH_PIXELS: begin
                span_color  = (r_kind == KIND_PLAYER_DRAW) ? byte_plus : r_in_byte;
                n_remaining = (cur_remaining != '0) ? cur_remaining - COORD_W'(1) : '0;
                if (cur_remaining <= COORD_W'(1)) begin
                    n_phase = PH_CMD;
                end
                do_span = 1'b1;
                do_adv  = 1'b1;
                adv_len = COORD_W'(1);
            end
            PH_EXT: begin
                n_phase = PH_CMD;
            end
            default: begin
                // Row start and command phases decode a command byte.
                n_kind = r_in_byte[3:0];
                unique case (r_in_byte[3:0])
                    KIND_SHORT_DRAW_0, KIND_SHORT_DRAW_1,
                    KIND_SHORT_DRAW_2, KIND_SHORT_DRAW_3: begin
                        n_remaining = {6'd0, r_in_byte[7:2]};
                        n_phase     = (r_in_byte[7:2] != '0) ? PH_PIXELS : PH_CMD;
                    end
                    KIND_SHORT_SKIP_0, KIND_SHORT_SKIP_1,
                    KIND_SHORT_SKIP_2, KIND_SHORT_SKIP_3: begin
                        do_adv  = 1'b1;
                        adv_len = {6'd0, r_in_byte[7:2]};
                        n_phase = PH_CMD;
                    end
                    KIND_LONG_DRAW, KIND_LONG_SKIP: begin
                        n_remaining = {r_in_byte[7:4], 8'd0};
                        n_phase     = PH_LONG_LO;
                    end
                    KIND_PLAYER_DRAW, KIND_FILL, KIND_PLAYER_FILL, KIND_SHADOW_FILL: begin
                        if (r_in_byte[7:4] == '0) begin
                            n_phase = PH_FILL_LEN;
                        end else begin
                            do_start    = 1'b1;
                            start_count = {8'd0, r_in_byte[7:4]};
                            start_kind  = r_in_byte[3:0];
                        end
                    end
                    KIND_EXTENDED: begin
                        n_phase = PH_EXT;
                    end
                    default: begin
                        // End of row: marker word, then wait for the next row.
                        marker  = 1'b1;
                        n_phase = PH_ROW_START;
                    end
                endcase
            end
        endcase

        // A counted command starts once its count is known.
        if (do_start) begin
            n_remaining = start_count;
            unique case (start_kind)
                KIND_PLAYER_DRAW: begin
                    n_phase = (start_count != '0) ? PH_PIXELS : PH_CMD;
                end
                KIND_FILL, KIND_PLAYER_FILL: begin
                    n_phase = PH_FILL_COLOR;
                end
                KIND_SHADOW_FILL: begin
                    n_phase    = PH_CMD;
                    span_color = SHADOW_COLOR;
                    do_span    = 1'b1;
                    do_adv     = 1'b1;
                    adv_len    = start_count;
                end
                default: begin
                    n_phase = PH_CMD;
                end
            endcase
        end
    end

    // Column advance saturates at the top of its range.
    assign col_sum  = {1'b0, cur_column} + {{(COLUMN_W+1-COORD_W){1'b0}}, adv_len};
    assign n_column = !do_adv ? cur_column :
                      (col_sum[COLUMN_W] ? {COLUMN_W{1'b1}} : col_sum[COLUMN_W-1:0]);

    // Span placement and clipping.
    assign clip_req.column       = cur_column;
    assign clip_req.offset       = cur_offset;
    assign clip_req.length       = adv_len;
    assign clip_req.row          = cur_row;
    assign clip_req.frame_width  = r_frame_width;
    assign clip_req.frame_height = r_frame_height;

    sprrle_span_clip #(
        .MAX_FRAME_SIDE(MAX_FRAME_SIDE)
    ) u_span_clip (
        .i_req(clip_req),
        .o_res(clip_res)
    );

    assign res_valid = marker || (do_span && clip_res.hit);

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ROW_START;
            r_kind      <= '0;
            r_remaining <= '0;
            r_column    <= '0;
            r_row       <= '0;
            r_offset    <= '0;
        end else if (stage_adv) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_remaining <= n_remaining;
            r_column    <= n_column;
            r_row       <= n_row;
            r_offset    <= n_offset;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= stage_adv && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv && res_valid) begin
            r_out_row   <= cur_row;
            r_out_end   <= marker;
            r_out_x     <= marker ? '0 : clip_res.x_start;
            r_out_run   <= marker ? '0 : clip_res.run_length;
            r_out_color <= marker ? '0 : span_color;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_row     = r_out_row;
    assign o_x_start     = r_out_x;
    assign o_run_length  = r_out_run;
    assign o_pixel_color = r_out_color;
    assign o_row_end     = r_out_end;

    // A row-end marker carries no span.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |->
            r_out_run == '0 && r_out_x == '0 && r_out_color == '0)
        else $error("row-end marker carries span data");

    // A span word always covers at least one pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_end |-> r_out_run != '0)
        else $error("empty span emitted");

    // A span word ends inside the frame width.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_end |->
            ({1'b0, r_out_x} + {1'b0, r_out_run}) <= clip_res.width_eff)
        else $error("span runs past frame width");

    // After an end-of-row byte the parser waits for a new row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && marker |=> r_phase == PH_ROW_START)
        else $error("parser did not rearm after end of row");

    // Pixel phase always has pixels left to take.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PIXELS |-> r_remaining != '0)
        else $error("pixel phase with zero count");

endmodule

// File: src/sprrle_span_clip.sv
// ----------------------------------------------------------------------------
// Sprite RLE span clipper
// Places a span at column plus left offset and clips it to the frame.
// ----------------------------------------------------------------------------
module sprrle_span_clip #(
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  sprrle_pkg::t_clip_req i_req,
    output sprrle_pkg::t_clip_res o_res
);
    import sprrle_pkg::*;

    localparam int POS_W = COLUMN_W + 2;

    logic [CFG_W-1:0]        width_eff;
    logic [CFG_W-1:0]        height_eff;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] lo_c;
    logic signed [POS_W-1:0] hi_c;
    logic signed [POS_W-1:0] w_s;
    logic signed [POS_W-1:0] span;
    logic                    row_ok;

    // Frame sizes above the supported side act as the side itself.
    assign width_eff  = ({19'd0, i_req.frame_width} > 32'(MAX_FRAME_SIDE)) ?
                        CFG_W'(MAX_FRAME_SIDE) : i_req.frame_width;
    assign height_eff = ({19'd0, i_req.frame_height} > 32'(MAX_FRAME_SIDE)) ?
                        CFG_W'(MAX_FRAME_SIDE) : i_req.frame_height;

    // Span ends in frame coordinates.
    assign lo  = $signed({2'b00, i_req.column})
               + $signed({{(POS_W-OFFSET_W){i_req.offset[OFFSET_W-1]}}, i_req.offset});
    assign hi  = lo + $signed({{(POS_W-COORD_W){1'b0}}, i_req.length});
    assign w_s = $signed({{(POS_W-CFG_W){1'b0}}, width_eff});

    // Clip against the left edge and the frame width.
    assign lo_c = lo[POS_W-1] ? '0 : lo;
    assign hi_c = (hi > w_s) ? w_s : hi;
    assign span = hi_c - lo_c;

    assign row_ok = {1'b0, i_req.row} < height_eff;

    assign o_res.hit        = row_ok && (hi_c > lo_c);
    assign o_res.x_start    = lo_c[COORD_W-1:0];
    assign o_res.run_length = span[COORD_W-1:0];
    assign o_res.width_eff  = width_eff;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite RLE row decoder testbench
// Streams row command words into the decoder with random gaps on the input
// and random stalls on the output. A behavioral decoder kept in the bench
// predicts every span and row-end word, and the monitor compares each output
// word field by field. Frame sizes are changed between phases while the
// decoder is idle.
// ----------------------------------------------------------------------------
module tb;
    import sprrle_pkg::*;

    localparam int MAX_SIDE    = 4096;
    localparam int MAX_WAIT    = 18;
    localparam int SETTLE      = 8;
    localparam int RUN_LIMIT   = 400000;
    localparam int PHASE_ITEMS = 95;
    localparam int MAX_REPORTS = 50;
    localparam int N_PHASES    = 7;

    // One word of the command stream.
    typedef struct packed {
        logic [7:0]                 data_byte;
        logic [COORD_W-1:0]         row;
        logic signed [OFFSET_W-1:0] left_offset;
    } t_stream_word;

    // One span or row-end word.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] run_length;
        logic [COLOR_W-1:0] color;
        logic               row_end;
    } t_span_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [7:0]                 i_data_byte = '0;
    logic [COORD_W-1:0]         i_row = '0;
    logic signed [OFFSET_W-1:0] i_left_offset = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [COORD_W-1:0]         o_out_row;
    logic [COORD_W-1:0]         o_x_start;
    logic [COORD_W-1:0]         o_run_length;
    logic [COLOR_W-1:0]         o_pixel_color;
    logic                       o_row_end;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    // Words waiting to be driven, words of the row under construction, and
    // the spans the decoder owes us.
    t_stream_word word_q[$];
    t_stream_word row_buf[$];
    t_span_word   spans_expected[$];

    int queued_words = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Bench copy of the decoder state and frame size.
    logic [CFG_W-1:0]           cfg_width = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]           cfg_height = FRAME_HEIGHT_RST;
    t_phase                     dec_phase = PH_ROW_START;
    logic [3:0]                 dec_kind = '0;
    logic [COORD_W-1:0]         dec_left = '0;
    logic [COLUMN_W-1:0]        dec_col = '0;
    logic [COORD_W-1:0]         dec_row = '0;
    logic signed [OFFSET_W-1:0] dec_ofs = '0;

    logic [CFG_W-1:0] phase_w [N_PHASES];
    logic [CFG_W-1:0] phase_h [N_PHASES];

    sprite_rle_row_decoder_top #(
        .MAX_FRAME_SIDE(MAX_SIDE)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_row         (i_row),
        .i_left_offset (i_left_offset),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_row     (o_out_row),
        .o_x_start     (o_x_start),
        .o_run_length  (o_run_length),
        .o_pixel_color (o_pixel_color),
        .o_row_end     (o_row_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Span prediction
    // ------------------------------------------------------------------

    // Frame sizes beyond the largest supported side behave as that side.
    function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        return (v > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : v;
    endfunction

    // The column saturates instead of wrapping.
    function automatic void advance_column(input logic [COORD_W-1:0] n);
        logic [COLUMN_W:0] sum;
        sum = {1'b0, dec_col} + {{(COLUMN_W+1-COORD_W){1'b0}}, n};
        dec_col = sum[COLUMN_W] ? {COLUMN_W{1'b1}} : sum[COLUMN_W-1:0];
    endfunction

    // Clip a span at the current column to the frame and queue it if any
    // pixel is left. The column moves by the full length either way.
    function automatic void place_span(input logic [COORD_W-1:0] len,
                                       input logic [COLOR_W-1:0] color);
        int lo;
        int hi;
        int w;
        lo = int'(dec_col) + int'(dec_ofs);
        hi = lo + int'(len);
        w = int'(clamp_side(cfg_width));
        if (lo < 0) lo = 0;
        if (hi > w) hi = w;
        if (int'(dec_row) < int'(clamp_side(cfg_height)) && hi > lo) begin
            spans_expected.push_back('{row: dec_row, x_start: COORD_W'(lo),
                                       run_length: COORD_W'(hi - lo), color: color,
                                       row_end: 1'b0});
        end
        advance_column(len);
    endfunction

    // A counted command whose count is now known.
    function automatic void start_counted(input logic [COORD_W-1:0] count);
        dec_left = count;
        case (dec_kind)
            KIND_PLAYER_DRAW: begin
                dec_phase = (dec_left != 0) ? PH_PIXELS : PH_CMD;
            end
            KIND_FILL, KIND_PLAYER_FILL: begin
                dec_phase = PH_FILL_COLOR;
            end
            KIND_SHADOW_FILL: begin
                dec_phase = PH_CMD;
                place_span(dec_left, SHADOW_COLOR);
            end
            default: begin
                dec_phase = PH_CMD;
            end
        endcase
    endfunction

    function automatic void decode_command(input logic [7:0] b);
        dec_kind = b[3:0];
        case (b[3:0])
            KIND_SHORT_DRAW_0, KIND_SHORT_DRAW_1, KIND_SHORT_DRAW_2,
            KIND_SHORT_DRAW_3: begin
                dec_left = {6'd0, b[7:2]};
                dec_phase = (dec_left != 0) ? PH_PIXELS : PH_CMD;
            end
            KIND_SHORT_SKIP_0, KIND_SHORT_SKIP_1, KIND_SHORT_SKIP_2,
            KIND_SHORT_SKIP_3: begin
                advance_column({6'd0, b[7:2]});
                dec_phase = PH_CMD;
            end
            KIND_LONG_DRAW, KIND_LONG_SKIP: begin
                dec_left = {b[7:4], 8'd0};
                dec_phase = PH_LONG_LO;
            end
            KIND_PLAYER_DRAW, KIND_FILL, KIND_PLAYER_FILL, KIND_SHADOW_FILL: begin
                // A zero high nibble means the count follows in the next word.
                if (b[7:4] == 4'd0) dec_phase = PH_FILL_LEN;
                else start_counted({8'd0, b[7:4]});
            end
            KIND_EXTENDED: begin
                dec_phase = PH_EXT;
            end
            default: begin
                spans_expected.push_back('{row: dec_row, x_start: '0, run_length: '0,
                                           color: '0, row_end: 1'b1});
                dec_phase = PH_ROW_START;
            end
        endcase
    endfunction

    // Advance the bench decoder by one accepted word.
    function automatic void decode_word(input logic [7:0] b,
                                        input logic [COORD_W-1:0] row,
                                        input logic signed [OFFSET_W-1:0] ofs);
        logic [COLOR_W-1:0] color;
        case (dec_phase)
            PH_ROW_START: begin
                dec_row = row;
                dec_ofs = ofs;
                dec_col = '0;
                dec_left = '0;
                decode_command(b);
            end
            PH_LONG_LO: begin
                dec_left = dec_left + {4'd0, b};
                dec_phase = PH_CMD;
                if (dec_kind == KIND_LONG_SKIP) begin
                    advance_column(dec_left);
                    dec_left = '0;
                end else if (dec_left != 0) begin
                    dec_phase = PH_PIXELS;
                end
            end
            PH_FILL_LEN: begin
                start_counted({4'd0, b});
            end
            PH_FILL_COLOR: begin
                color = (dec_kind == KIND_PLAYER_FILL) ? b + PLAYER_COLOR_OFS : b;
                dec_phase = PH_CMD;
                place_span(dec_left, color);
            end
            PH_PIXELS: begin
                color = (dec_kind == KIND_PLAYER_DRAW) ? b + PLAYER_COLOR_OFS : b;
                if (dec_left != 0) dec_left = dec_left - COORD_W'(1);
                if (dec_left == 0) dec_phase = PH_CMD;
                place_span(COORD_W'(1), color);
            end
            PH_EXT: begin
                dec_phase = PH_CMD;
            end
            default: begin
                decode_command(b);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Row and offset only matter on the first word of a row; the rest get
    // random values so that the latch is exercised.
    task automatic put_byte(input logic [7:0] b);
        row_buf.push_back('{data_byte: b, row: COORD_W'($urandom),
                            left_offset: OFFSET_W'($urandom)});
    endtask

    task automatic put_lead(input logic [7:0] b, input logic [COORD_W-1:0] row,
                            input logic [OFFSET_W-1:0] ofs);
        row_buf.push_back('{data_byte: b, row: row, left_offset: ofs});
    endtask

    task automatic flush_row();
        foreach (row_buf[k]) word_q.push_back(row_buf[k]);
        queued_words += row_buf.size();
        row_buf.delete();
    endtask

    // One well-formed command with random content. End of row is left out.
    task automatic gen_command();
        logic [3:0] kind;
        logic [3:0] hi_nib;
        logic [7:0] lo_byte;
        int count;
        kind = 4'($urandom_range(0, 14));
        case (kind)
            KIND_SHORT_DRAW_0, KIND_SHORT_DRAW_1, KIND_SHORT_DRAW_2,
            KIND_SHORT_DRAW_3: begin
                hi_nib = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                     : 4'($urandom_range(0, 1));
                put_byte({hi_nib, kind});
                count = int'({hi_nib, kind[3:2]});
                repeat (count) put_byte(8'($urandom));
            end
            KIND_SHORT_SKIP_0, KIND_SHORT_SKIP_1, KIND_SHORT_SKIP_2,
            KIND_SHORT_SKIP_3: begin
                put_byte({4'($urandom), kind});
            end
            KIND_LONG_DRAW: begin
                // Counts of 256 and more are kept rare to bound the run.
                hi_nib = ($urandom_range(0, 49) == 0) ? 4'd1 : 4'd0;
                lo_byte = (hi_nib != 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
                put_byte({hi_nib, kind});
                put_byte(lo_byte);
                count = int'({hi_nib, lo_byte});
                repeat (count) put_byte(8'($urandom));
            end
            KIND_LONG_SKIP: begin
                put_byte({4'($urandom), kind});
                put_byte(8'($urandom));
            end
            KIND_PLAYER_DRAW: begin
                hi_nib = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                put_byte({hi_nib, kind});
                if (hi_nib == 0) begin
                    lo_byte = 8'($urandom_range(0, 12));
                    put_byte(lo_byte);
                    count = int'(lo_byte);
                end else begin
                    count = int'(hi_nib);
                end
                repeat (count) put_byte(8'($urandom));
            end
            KIND_FILL, KIND_PLAYER_FILL, KIND_SHADOW_FILL: begin
                hi_nib = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom);
                put_byte({hi_nib, kind});
                if (hi_nib == 0) put_byte(8'($urandom));
                if (kind != KIND_SHADOW_FILL) put_byte(8'($urandom));
            end
            default: begin
                // Extended command and the word it swallows.
                put_byte({4'($urandom), kind});
                put_byte(8'($urandom));
            end
        endcase
    endtask

    // One row: mostly well formed, some noise, some cut short, and now and
    // then a row long enough to saturate the column.
    task automatic gen_row();
        int pick;
        int keep;
        int w_eff;
        int h_eff;
        logic [COORD_W-1:0] row_no;
        logic [OFFSET_W-1:0] ofs;
        w_eff = int'(clamp_side(cfg_width));
        h_eff = int'(clamp_side(cfg_height));
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
        end else if (pick == 1) begin
            repeat (17) begin
                put_byte({4'hF, KIND_LONG_SKIP});
                put_byte(8'hFF);
            end
            put_byte({4'h0, KIND_SHORT_DRAW_1});
            put_byte(8'($urandom));
            put_byte({4'h0, KIND_END_ROW});
        end else begin
            repeat ($urandom_range(1, 8)) gen_command();
            put_byte({4'h0, KIND_END_ROW});
            if (pick == 2) begin
                keep = $urandom_range(1, row_buf.size() - 1);
                while (row_buf.size() > keep) void'(row_buf.pop_back());
            end
        end
        case ($urandom_range(0, 3))
            0: row_no = COORD_W'($urandom);
            1: row_no = COORD_W'(h_eff + $urandom_range(0, 2) - 1);
            default: row_no = (h_eff == 0) ? COORD_W'($urandom)
                                           : COORD_W'($urandom_range(0, h_eff - 1));
        endcase
        case ($urandom_range(0, 3))
            0: ofs = OFFSET_W'($urandom);
            1: ofs = OFFSET_W'(w_eff - $urandom_range(0, 40));
            2: ofs = OFFSET_W'($urandom_range(0, 128) - 64);
            default: ofs = OFFSET_W'($urandom_range(0, 200));
        endcase
        row_buf[0].row = row_no;
        row_buf[0].left_offset = ofs;
        flush_row();
    endtask

    task automatic gen_phase();
        int start;
        start = queued_words;
        while (queued_words - start < PHASE_ITEMS) gen_row();
    endtask

    // Wait until every word is in and every span is out, then let the
    // pipeline settle so that frame sizes may change safely.
    task automatic drain_idle();
        while (word_q.size() != 0 || i_valid || spans_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_width = w;
        cfg_height = h;
    endtask

    // Directed rows under the reset frame size, then random phases.
    initial begin
        phase_w = '{13'd4096, 13'd1, 13'd0, 13'd8191,
                    CFG_W'($urandom_range(1, 4096)), 13'd640, 13'd37};
        phase_h = '{13'd4096, 13'd1, 13'd0, 13'd8191,
                    CFG_W'($urandom_range(1, 4096)), 13'd480, 13'd4097};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every command, zero counts, colour extremes and a span past the
        // right edge after a long skip.
        put_lead(8'h08, 12'd5, 16'd3);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'hFD);
        put_byte(8'h02);
        put_byte(8'h02);
        put_byte(8'h11);
        put_byte(8'h22);
        put_byte(8'h02);
        put_byte(8'h00);
        put_byte(8'h26);
        put_byte(8'hF0);
        put_byte(8'h01);
        put_byte(8'h06);
        put_byte(8'h01);
        put_byte(8'hFF);
        put_byte(8'h37);
        put_byte(8'hAB);
        put_byte(8'h07);
        put_byte(8'h00);
        put_byte(8'h55);
        put_byte(8'h4A);
        put_byte(8'hF5);
        put_byte(8'h0B);
        put_byte(8'hFF);
        put_byte(8'h0E);
        put_byte(8'h0F);
        put_byte(8'hF3);
        put_byte(8'hFF);
        put_byte(8'h04);
        put_byte(8'h77);
        put_byte(8'h0F);
        // Row beyond the frame height: no span, but the marker still comes.
        put_lead(8'hF7, 12'd4095, 16'h8000);
        put_byte(8'h42);
        put_byte(8'h0F);
        // Span clipped at the left edge.
        put_lead(8'h37, 12'd0, 16'hFFFE);
        put_byte(8'h99);
        put_byte(8'h0F);
        // Span lying wholly right of the frame.
        put_lead(8'h04, 12'd1, 16'h7FFF);
        put_byte(8'h12);
        put_byte(8'h0F);
        flush_row();
        gen_phase();
        drain_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            write_frame(phase_w[p], phase_h[p]);
            gen_phase();
            drain_idle();
        end

        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------

    function automatic int draw_wait(input logic quiet);
        if (quiet || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Presents one word at a time; after each accepted word the next one
    // waits a random number of cycles, except during quiet stretches.
    always @(posedge i_clk) begin : drive_words
        t_stream_word nxt;
        static int src_wait = 0;
        static logic src_quiet = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) decode_word(i_data_byte, i_row, i_left_offset);
            if (!i_valid || !o_stall) begin
                if (src_wait != 0) begin
                    src_wait--;
                    i_valid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    nxt = word_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= nxt.data_byte;
                    i_row <= nxt.row;
                    i_left_offset <= nxt.left_offset;
                    if ($urandom_range(0, 49) == 0) src_quiet = !src_quiet;
                    src_wait = draw_wait(src_quiet);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Checks each accepted word against the oldest prediction, then draws
    // how long to stall before taking the next one.
    always @(posedge i_clk) begin : watch_spans
        t_span_word got;
        t_span_word want;
        static int snk_wait = 0;
        static logic snk_quiet = 1'b0;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{row: o_out_row, x_start: o_x_start, run_length: o_run_length,
                    color: o_pixel_color, row_end: o_row_end};
            if (spans_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected word row %0d x %0d len %0d",
                                          got.row, got.x_start, got.run_length));
            end else begin
                want = spans_expected.pop_front();
                if (got.row != want.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              got.row, want.row));
                if (got.x_start != want.x_start)
                    report_mismatch($sformatf("x_start %0d, expected %0d",
                                              got.x_start, want.x_start));
                if (got.run_length != want.run_length)
                    report_mismatch($sformatf("run_length %0d, expected %0d",
                                              got.run_length, want.run_length));
                if (got.color != want.color)
                    report_mismatch($sformatf("pixel_color %0d, expected %0d",
                                              got.color, want.color));
                if (got.row_end != want.row_end)
                    report_mismatch($sformatf("row_end %0d, expected %0d",
                                              got.row_end, want.row_end));
            end
            if ($urandom_range(0, 49) == 0) snk_quiet = !snk_quiet;
            snk_wait = draw_wait(snk_quiet);
        end
        i_stall <= (snk_wait != 0);
        if (snk_wait != 0) snk_wait--;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
